FILE: hw/rtl/lppf_pkg.sv
// Shared types, constants and helpers of the letter pool pair finder.
// Depends on nothing; the files that use it refer to it by scoped names.
package lppf_pkg;

   localparam int MAX_WORDS = 64;
   localparam int ALPHABET  = 26;
   localparam int IDX_W     = $clog2(MAX_WORDS);
   localparam int CNT_W     = $clog2(MAX_WORDS + 1);
   localparam int OUT_IDX_W = 6;
   localparam int LEN_W     = 12;
   localparam int COUNT_W   = 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [LEN_W-1:0]   LEN_MAX   = '1;

   localparam logic [7:0] CHAR_UPPER_A = 8'd65;
   localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
   localparam logic [7:0] CHAR_LOWER_A = 8'd97;
   localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
   localparam logic [7:0] CASE_FOLD    = 8'd32;
   localparam logic [7:0] CHAR_LF      = 8'd10;
   localparam logic [7:0] CHAR_CR      = 8'd13;

   localparam logic [1:0] OP_POOL_CHAR = 2'd0;
   localparam logic [1:0] OP_WORD_CHAR = 2'd1;
   localparam logic [1:0] OP_WORD_END  = 2'd2;
   localparam logic [1:0] OP_CLEAR     = 2'd3;

   typedef logic [ALPHABET-1:0][COUNT_W-1:0] counts_type;

   typedef struct packed {
      logic       is_letter;
      logic [4:0] slot;
   } letter_type;

   // Fold case, then map a..z onto slots 0..25.
   function automatic letter_type letter_of(input logic [7:0] b);
      logic [7:0] folded;
      letter_type r;
      folded = b;
      if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
         folded = b + CASE_FOLD;
      end
      r.is_letter = (folded >= CHAR_LOWER_A) && (folded <= CHAR_LOWER_Z);
      r.slot      = 5'(folded - CHAR_LOWER_A);
      return r;
   endfunction

   // Mask a store index onto the output field width.
   function automatic logic [OUT_IDX_W-1:0] out_index(input logic [31:0] v);
      return v[OUT_IDX_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/lppf_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module lppf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         store_ff[write_address] <= write_data;
      end
      read_data_ff <= store_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

FILE: hw/rtl/lppf_fit_check.sv
// Shared containment unit: stored + word counts within the pool, per letter.
// Depends on lppf_pkg.
module lppf_fit_check (
   input  lppf_pkg::counts_type pool_counts,
   input  lppf_pkg::counts_type word_counts,
   input  lppf_pkg::counts_type stored_counts,
   output logic                 fits
);

   always_comb begin
      logic [lppf_pkg::COUNT_W:0] sum;
      fits = 1'b1;
      for (int k = 0; k < lppf_pkg::ALPHABET; k++) begin
         sum = {1'b0, stored_counts[k]} + {1'b0, word_counts[k]};
         if (sum > {1'b0, pool_counts[k]}) begin
            fits = 1'b0;
         end
      end
   end

endmodule

FILE: hw/rtl/letter_pool_pair_finder_unit.sv
// Top level of the letter pool pair finder: command port, sequencer, store.
// Depends on lppf_pkg, lppf_ram and lppf_fit_check.
//
// A transaction is taken when start is high and busy is low. Pool, word
// and clear commands leave busy low. A word end that keeps its word while
// others are stored keeps busy high through the scan, flush and final states:
// the stored words are read from the word RAM one per cycle through its
// single read port and checked by one shared containment unit. Each pair
// appears on the rsp_ ports for exactly one cycle with rsp_strobe high; the
// receiver cannot hold results off, so it must take every strobe. Pairs come
// out in rising first_index order, the final one of a word end with rsp_last
// set, and the last pair may appear in the first cycle after busy falls.
// A dropped word, or the first word stored, gives no result; busy stays low.
module letter_pool_pair_finder_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_operation,
   input  logic [7:0]                          req_char_byte,
   input  logic                                csr_write_enable,
   input  logic [lppf_pkg::LEN_W-1:0]          csr_write_data,
   output logic                                rsp_strobe,
   output logic [lppf_pkg::OUT_IDX_W-1:0]      rsp_first_index,
   output logic [lppf_pkg::OUT_IDX_W-1:0]      rsp_second_index,
   output logic                                rsp_last
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;
   localparam logic [1:0] ST_FINAL = 2'd3;

   localparam int IDX_W = lppf_pkg::IDX_W;
   localparam int CNT_W = lppf_pkg::CNT_W;

   // Sequencer and counters
   logic [1:0]                 state_ff, state_in;
   logic [IDX_W-1:0]           addr_ff, addr_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [lppf_pkg::LEN_W-1:0] min_len_ff, min_len_in;

   // Letter counts
   lppf_pkg::counts_type       pool_ff, pool_in;
   lppf_pkg::counts_type       word_ff, word_in;
   logic [lppf_pkg::LEN_W-1:0] len_ff, len_in;

   // Compare stage and pending pair
   logic                       cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]           cmp_index_ff, cmp_index_in;
   logic                       pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]           pend_index_ff, pend_index_in;

   // Result register
   logic                           rsp_strobe_ff, rsp_strobe_in;
   logic [lppf_pkg::OUT_IDX_W-1:0] rsp_first_ff, rsp_first_in;
   logic [lppf_pkg::OUT_IDX_W-1:0] rsp_second_ff, rsp_second_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                 accept;
   logic                 take_word;
   logic                 fits;
   logic                 ram_we;
   lppf_pkg::counts_type ram_rd_data;
   lppf_pkg::counts_type check_stored;
   lppf_pkg::letter_type letter;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);
   assign letter = lppf_pkg::letter_of(req_char_byte);

   // While idle the shared unit checks the word against the pool alone;
   // while scanning it adds the stored word read last cycle.
   assign check_stored = (state_ff == ST_IDLE) ? '0 : ram_rd_data;

   lppf_fit_check u_fit_check (
      .pool_counts   (pool_ff),
      .word_counts   (word_ff),
      .stored_counts (check_stored),
      .fits          (fits)
   );

   assign take_word = (len_ff >= min_len_ff) && fits
                      && (count_ff < CNT_W'(lppf_pkg::MAX_WORDS));
   assign ram_we    = accept && (req_operation == lppf_pkg::OP_WORD_END) && take_word;

   lppf_ram #(
      .WIDTH ($bits(lppf_pkg::counts_type)),
      .DEPTH (lppf_pkg::MAX_WORDS)
   ) u_word_ram (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (count_ff[IDX_W-1:0]),
      .write_data    (word_ff),
      .read_address  (addr_ff),
      .read_data     (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      count_in      = count_ff;
      pool_in       = pool_ff;
      word_in       = word_ff;
      len_in        = len_ff;
      cmp_valid_in  = 1'b0;
      cmp_index_in  = addr_ff;
      pend_valid_in = pend_valid_ff;
      pend_index_in = pend_index_ff;
      rsp_strobe_in = 1'b0;
      rsp_first_in  = lppf_pkg::out_index(32'(pend_index_ff));
      rsp_second_in = lppf_pkg::out_index(32'(count_ff));
      rsp_last_in   = 1'b0;
      min_len_in    = csr_write_enable ? csr_write_data : min_len_ff;

      // Retire a fitting compare: send the older pending pair, hold this one.
      if (cmp_valid_ff && fits) begin
         if (pend_valid_ff) begin
            rsp_strobe_in = 1'b1;
         end
         pend_valid_in = 1'b1;
         pend_index_in = cmp_index_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_operation)
                  lppf_pkg::OP_POOL_CHAR: begin
                     if (letter.is_letter && pool_ff[letter.slot] != lppf_pkg::COUNT_MAX) begin
                        pool_in[letter.slot] = pool_ff[letter.slot] + 1'b1;
                     end
                  end
                  lppf_pkg::OP_WORD_CHAR: begin
                     if (req_char_byte != lppf_pkg::CHAR_LF
                         && req_char_byte != lppf_pkg::CHAR_CR) begin
                        if (len_ff != lppf_pkg::LEN_MAX) begin
                           len_in = len_ff + 1'b1;
                        end
                        if (letter.is_letter
                            && word_ff[letter.slot] != lppf_pkg::COUNT_MAX) begin
                           word_in[letter.slot] = word_ff[letter.slot] + 1'b1;
                        end
                     end
                  end
                  lppf_pkg::OP_WORD_END: begin
                     if (take_word && count_ff != '0) begin
                        // Keep the word counts until the scan is done.
                        state_in      = ST_SCAN;
                        addr_in       = '0;
                        pend_valid_in = 1'b0;
                     end else begin
                        if (take_word) begin
                           count_in = count_ff + 1'b1;
                        end
                        word_in = '0;
                        len_in  = '0;
                     end
                  end
                  lppf_pkg::OP_CLEAR: begin
                     pool_in  = '0;
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            cmp_valid_in = 1'b1;
            cmp_index_in = addr_ff;
            if (CNT_W'(addr_ff) == count_ff - CNT_W'(1)) begin
               state_in = ST_FLUSH;
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end
         ST_FLUSH: begin
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            // Drain the held pair as the last one and commit the new word.
            if (pend_valid_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_last_in   = 1'b1;
            end
            pend_valid_in = 1'b0;
            count_in      = count_ff + 1'b1;
            word_in       = '0;
            len_in        = '0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         min_len_ff    <= lppf_pkg::LEN_W'(1);
         pool_ff       <= '0;
         word_ff       <= '0;
         len_ff        <= '0;
         cmp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         min_len_ff    <= min_len_in;
         pool_ff       <= pool_in;
         word_ff       <= word_in;
         len_ff        <= len_in;
         cmp_valid_ff  <= cmp_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      cmp_index_ff  <= cmp_index_in;
      pend_index_ff <= pend_index_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_first_index  = rsp_first_ff;
   assign rsp_second_index = rsp_second_ff;
   assign rsp_last         = rsp_last_ff;

   // A result is only ever produced by a word end in progress.
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a word end in progress");

   // A pair that is not the last must leave the scan running.
   a_not_last_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> busy)
      else $error("non-final pair after the scan finished");

   // Back-to-back pairs of one word end share the new word's index.
   a_same_second: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(rsp_strobe) && !$past(rsp_last))
         |-> (rsp_second_index == $past(rsp_second_index)))
      else $error("second index changed within one word end");

   // A scan only starts with at least one stored word.
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (count_ff != '0))
      else $error("scan running over an empty store");

endmodule
